@@ rtl/edf_pkg.sv @@
// Shared constants, types and helpers for the EDF tick scheduler.
`default_nettype none

package edf_pkg;

  localparam int MAX_TASKS = 4;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int TIME_W    = 32;
  localparam int DL_W      = 32;
  localparam int SRV_W     = 16;
  localparam int HALF_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TASKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_HIGH    = 3'd4;

  localparam logic [NUM_W-1:0] NUM_TASKS_RST = 3'd4;
  localparam logic [CFG_W-1:0] PAIR_RST      = 32'h0001_0001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic start;       // rewind task index, drop current best
    logic clear_step;  // reinitialize one task entry
    logic scan_step;   // compare one task against current best
    logic commit;      // update chosen task, time and result register
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;  // index at last physical task
    logic scan_last;   // index at last active task
    logic out_busy;    // result register full and not taken this cycle
  } dp_stat_t;

  // 16-bit field of a packed pair, zero read as one
  function automatic logic [HALF_W-1:0] half_of(input logic [CFG_W-1:0] low,
                                                input logic [CFG_W-1:0] high,
                                                input logic [IDX_W-1:0] idx);
    logic [CFG_W-1:0]  word;
    logic [HALF_W-1:0] v;
    word = idx[1] ? high : low;
    v    = idx[0] ? word[31:16] : word[15:0];
    return (v == '0) ? HALF_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/edf_ctrl.sv @@
// Sequencing FSM: accept, optional state clear sweep, task scan, commit.
`default_nettype none

module edf_ctrl
  import edf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_restart,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_restart ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_CLEAR: begin
        if (stat.sweep_last) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        cmd.start      = stat.sweep_last;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.commit = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/edf_dp.sv @@
// Datapath: config registers, per-task deadline/served state, scan and result register.
`default_nettype none

module edf_dp
  import edf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_idle,
  output logic [IDX_W-1:0]          out_task_index,
  output logic                      out_job_done,
  output logic [TIME_W-1:0]         out_slot_time
);

  logic [NUM_W-1:0] num_tasks_r;
  logic [CFG_W-1:0] per_lo_r, per_hi_r, exe_lo_r, exe_hi_r;

  logic [TIME_W-1:0] time_r;
  logic [DL_W-1:0]   dl_r  [MAX_TASKS];
  logic [SRV_W-1:0]  srv_r [MAX_TASKS];

  logic [IDX_W-1:0] idx_r;
  logic             found_r;
  logic [DL_W-1:0]  best_r;
  logic [IDX_W-1:0] chosen_r;
  logic [SRV_W-1:0] best_srv_r;

  logic             out_valid_r;
  logic             out_idle_r;
  logic [IDX_W-1:0] out_task_r;
  logic             out_done_r;
  logic [TIME_W-1:0] out_time_r;

  // Active task count clamped to 1..MAX_TASKS
  logic [NUM_W-1:0] n_eff;
  logic [IDX_W-1:0] last_active;

  always_comb begin
    n_eff = num_tasks_r;
    if (num_tasks_r == '0) begin
      n_eff = NUM_W'(1);
    end else if (num_tasks_r > NUM_W'(MAX_TASKS)) begin
      n_eff = NUM_W'(MAX_TASKS);
    end
    last_active = IDX_W'(n_eff - NUM_W'(1));
  end

  // Scan: task at idx_r is released if deadline <= now + period
  logic [DL_W-1:0]   dl_cur;
  logic [HALF_W-1:0] per_cur;
  logic [TIME_W:0]   reach;
  logic              eligible, take;

  always_comb begin
    dl_cur   = dl_r[idx_r];
    per_cur  = half_of(per_lo_r, per_hi_r, idx_r);
    reach    = {1'b0, time_r} + {{(TIME_W + 1 - HALF_W){1'b0}}, per_cur};
    eligible = ({1'b0, dl_cur} <= reach);
    take     = eligible && (!found_r || (dl_cur < best_r));
  end

  // Commit: served count, job completion, saturating deadline advance
  logic [HALF_W-1:0] per_ch, exe_ch;
  logic [SRV_W:0]    srv_inc;
  logic              done;
  logic [DL_W:0]     dl_adv;
  logic [DL_W-1:0]   dl_sat;
  logic [TIME_W-1:0] time_nxt;

  always_comb begin
    per_ch   = half_of(per_lo_r, per_hi_r, chosen_r);
    exe_ch   = half_of(exe_lo_r, exe_hi_r, chosen_r);
    srv_inc  = {1'b0, best_srv_r} + (SRV_W + 1)'(1);
    done     = found_r && (srv_inc >= {{(SRV_W + 1 - HALF_W){1'b0}}, exe_ch});
    dl_adv   = {1'b0, best_r} + {{(DL_W + 1 - HALF_W){1'b0}}, per_ch};
    dl_sat   = dl_adv[DL_W] ? '1 : dl_adv[DL_W-1:0];
    time_nxt = (time_r == '1) ? time_r : time_r + TIME_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tasks_r <= NUM_TASKS_RST;
      per_lo_r    <= PAIR_RST;
      per_hi_r    <= PAIR_RST;
      exe_lo_r    <= PAIR_RST;
      exe_hi_r    <= PAIR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_TASKS:    num_tasks_r <= cfg_wdata[NUM_W-1:0];
        REG_PERIODS_LOW:  per_lo_r    <= cfg_wdata;
        REG_PERIODS_HIGH: per_hi_r    <= cfg_wdata;
        REG_EXEC_LOW:     exe_lo_r    <= cfg_wdata;
        REG_EXEC_HIGH:    exe_hi_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        dl_r[i]  <= DL_W'(1);
        srv_r[i] <= '0;
      end
    end else begin
      if (cmd.start) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.clear_step || cmd.scan_step) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (cmd.clear_step) begin
        dl_r[idx_r]  <= DL_W'(half_of(per_lo_r, per_hi_r, idx_r));
        srv_r[idx_r] <= '0;
        time_r       <= '0;
      end

      if (cmd.scan_step && take) begin
        found_r <= 1'b1;
      end

      if (cmd.commit) begin
        if (found_r) begin
          if (done) begin
            dl_r[chosen_r]  <= dl_sat;
            srv_r[chosen_r] <= '0;
          end else begin
            srv_r[chosen_r] <= srv_inc[SRV_W-1:0];
          end
        end
        time_r      <= time_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      best_r     <= dl_cur;
      chosen_r   <= idx_r;
      best_srv_r <= srv_r[idx_r];
    end
    if (cmd.commit) begin
      out_idle_r <= !found_r;
      out_task_r <= found_r ? chosen_r : '0;
      out_done_r <= done;
      out_time_r <= time_r;
    end
  end

  always_comb begin
    stat.sweep_last = (idx_r == IDX_W'(MAX_TASKS - 1));
    stat.scan_last  = (idx_r == last_active);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_idle       = out_idle_r;
  assign out_task_index = out_task_r;
  assign out_job_done   = out_done_r;
  assign out_slot_time  = out_time_r;

endmodule

`default_nettype wire

@@ rtl/edf_tick_scheduler.sv @@
// EDF tick scheduler top level: controller plus datapath.
//
// Each input transaction on in_* advances the schedule by one time slot and
// yields exactly one result transaction on out_*: idle flag, chosen task,
// job completion flag and the slot's time index. in_restart=1 reloads every
// deadline from its period, clears served counts and time, then schedules.
// Configuration is written through cfg_we/cfg_index/cfg_wdata between slots.
// A slot is handled in steps: the accept cycle, a deadline scan over the
// active tasks (a single comparator walks them one at a time) and a commit,
// which waits while the result register is still full; a restart adds a
// clear sweep over all task entries before the scan. in_ready is high only
// while the controller waits for a slot.
// The result sits in an output register; the next slot is taken and scanned
// while it waits, and only the commit waits for out_ready.
// Synchronous reset loads the register reset values, clears time, sets all
// deadlines to 1 and empties the result register.
`default_nettype none

module edf_tick_scheduler
  import edf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_restart,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_idle,
  output logic [IDX_W-1:0]          out_task_index,
  output logic                      out_job_done,
  output logic [TIME_W-1:0]         out_slot_time
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  edf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .stat       (stat),
    .cmd        (cmd)
  );

  edf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_idle       (out_idle),
    .out_task_index (out_task_index),
    .out_job_done   (out_job_done),
    .out_slot_time  (out_slot_time)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the EDF tick scheduler.
`timescale 1ns / 1ps

module tb
  import edf_pkg::*;
();

  localparam int HOLD_LIMIT = 2000;  // cycles without any transaction
  localparam int SETTLE     = 16;    // extra idle cycles after each drain
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_EXEC_HIGH + CFG_IDX_W'(1);

  typedef struct packed {
    logic              idle;
    logic [IDX_W-1:0]  task_id;
    logic              done;
    logic [TIME_W-1:0] stamp;
  } slot_result_t;

  class slot_tracker;
    logic [NUM_W-1:0]  num_reg;
    logic [CFG_W-1:0]  per_lo, per_hi, ex_lo, ex_hi;
    logic [TIME_W-1:0] now_t;
    logic [DL_W-1:0]   deadline [MAX_TASKS];
    logic [SRV_W-1:0]  served [MAX_TASKS];
    slot_result_t      pending_slots [$];
    int                mismatches;
    int                checked;

    function logic [HALF_W-1:0] pick_half(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, int i);
      logic [CFG_W-1:0]  w;
      logic [HALF_W-1:0] h;
      w = (i >= 2) ? hi : lo;
      h = (i % 2 == 1) ? w[31:16] : w[15:0];
      return (h == '0) ? HALF_W'(1) : h;
    endfunction

    function logic [HALF_W-1:0] period(int i);
      return pick_half(per_lo, per_hi, i);
    endfunction

    function logic [HALF_W-1:0] exec_len(int i);
      return pick_half(ex_lo, ex_hi, i);
    endfunction

    function void reload();
      now_t = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        deadline[i] = DL_W'(period(i));
        served[i]   = '0;
      end
    endfunction

    function void reset_all();
      num_reg = NUM_TASKS_RST;
      per_lo  = PAIR_RST;
      per_hi  = PAIR_RST;
      ex_lo   = PAIR_RST;
      ex_hi   = PAIR_RST;
      reload();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_NUM_TASKS:    num_reg = val[NUM_W-1:0];
        REG_PERIODS_LOW:  per_lo = val;
        REG_PERIODS_HIGH: per_hi = val;
        REG_EXEC_LOW:     ex_lo = val;
        REG_EXEC_HIGH:    ex_hi = val;
        default: ;
      endcase
    endfunction

    // advance one slot and queue the result it must produce
    function void note_slot(logic restart);
      int              n;
      int              pick;
      logic            found;
      logic [DL_W-1:0] best;
      logic [TIME_W:0] reach;
      logic [SRV_W:0]  cnt;
      logic [DL_W:0]   nd;
      slot_result_t    r;
      if (restart) reload();
      n = (num_reg == 0) ? 1 : ((num_reg > MAX_TASKS) ? MAX_TASKS : int'(num_reg));
      found = 1'b0;
      pick  = 0;
      best  = '0;
      for (int i = 0; i < n; i++) begin
        reach = {1'b0, now_t} + (TIME_W + 1)'(period(i));
        if ({1'b0, deadline[i]} <= reach && (!found || deadline[i] < best)) begin
          found = 1'b1;
          best  = deadline[i];
          pick  = i;
        end
      end
      r.done = 1'b0;
      if (found) begin
        cnt = {1'b0, served[pick]} + 1'b1;
        if (cnt >= (SRV_W + 1)'(exec_len(pick))) begin
          nd = {1'b0, deadline[pick]} + (DL_W + 1)'(period(pick));
          deadline[pick] = nd[DL_W] ? '1 : nd[DL_W-1:0];
          served[pick]   = '0;
          r.done         = 1'b1;
        end else begin
          served[pick] = cnt[SRV_W-1:0];
        end
      end
      r.stamp = now_t;
      if (now_t != '1) now_t++;
      r.idle    = !found;
      r.task_id = found ? IDX_W'(pick) : '0;
      pending_slots.push_back(r);
    endfunction

    function void check_slot(slot_result_t got);
      slot_result_t want;
      if (pending_slots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idle=%0b task=%0d done=%0b time=%0d",
                   got.idle, got.task_id, got.done, got.stamp);
        return;
      end
      want = pending_slots.pop_front();
      if (got.idle !== want.idle || got.task_id !== want.task_id ||
          got.done !== want.done || got.stamp !== want.stamp) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"slot %0d: expected idle=%0b task=%0d done=%0b time=%0d, ",
                    "got idle=%0b task=%0d done=%0b time=%0d"},
                   checked, want.idle, want.task_id, want.done, want.stamp,
                   got.idle, got.task_id, got.done, got.stamp);
      end
      checked++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_idle;
  logic [IDX_W-1:0]     out_task_index;
  logic                 out_job_done;
  logic [TIME_W-1:0]    out_slot_time;

  slot_tracker sb;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int          rx_hold = 0;
  int          quiet_cycles = 0;

  edf_tick_scheduler i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_idle       (out_idle),
    .out_task_index (out_task_index),
    .out_job_done   (out_job_done),
    .out_slot_time  (out_slot_time)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, checking on each transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_slot(slot_result_t'({out_idle, out_task_index, out_job_done, out_slot_time}));
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
      rx_hold = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= HOLD_LIMIT) begin
      $display("** edf_tick_scheduler: FAILED **");
      $finish;
    end
  end

  // valid stays high after a transaction until the next gap or pause lowers it
  task automatic send_slot(input logic restart);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_slot(restart);
  endtask

  // hold off the sender until every expected result is back
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (sb.pending_slots.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [NUM_W-1:0] num, input logic [CFG_W-1:0] pl,
                              input logic [CFG_W-1:0] ph, input logic [CFG_W-1:0] el,
                              input logic [CFG_W-1:0] eh, input bit junk);
    write_reg(REG_NUM_TASKS, CFG_W'(num));
    write_reg(REG_PERIODS_LOW, pl);
    if (junk)
      write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
    write_reg(REG_PERIODS_HIGH, ph);
    write_reg(REG_EXEC_LOW, el);
    write_reg(REG_EXEC_HIGH, eh);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count, input logic first_restart, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      if (i == 0)
        send_slot(first_restart);
      else
        send_slot($urandom_range(0, 99) < restart_pct);
      if ($urandom_range(0, 99) == 0) drain(0);
    end
    drain(SETTLE);
  endtask

  function automatic logic [HALF_W-1:0] rand_half(input bit is_period);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 13) return '1;
    if (r < 19) return HALF_W'($urandom);
    return is_period ? HALF_W'($urandom_range(1, 8)) : HALF_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [CFG_W-1:0] rand_pair(input bit is_period);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return {rand_half(is_period), rand_half(is_period)};
  endfunction

  initial begin
    int sent;
    logic [NUM_W-1:0] num;
    sb = new();
    sb.reset_all();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: four tasks, every period and execution time 1
    run_phase(3, 1'b0, 0);
    run_phase(1, 1'b1, 0);
    // zero task count and zero fields read as one; unused register indexes ignored
    program_regs('0, '0, '0, '0, '0, 1'b1);
    write_reg(REG_UNUSED_FIRST, '1);
    write_reg(REG_UNUSED_FIRST + CFG_IDX_W'(2), '1);
    cfg_we <= 1'b0;
    run_phase(2, 1'b1, 0);
    // task count above the maximum, widest periods and execution times
    program_regs('1, '1, '1, 32'hFFFF_0001, 32'h0002_0003, 1'b0);
    run_phase(4, 1'b1, 0);
    // build up served counts, then raise periods and cut execution times
    program_regs(NUM_W'(2), 32'h0002_0002, '0, 32'h0005_0005, '0, 1'b0);
    run_phase(4, 1'b1, 0);
    program_regs(NUM_W'(2), 32'h0100_0100, '0, 32'h0001_0001, '0, 1'b0);
    run_phase(3, 1'b0, 0);
    run_phase(1, 1'b1, 0);

    sent = 0;
    while (sent < 1750) begin
      int count;
      count = $urandom_range(60, 200);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      num = ($urandom_range(0, 99) < 80) ? NUM_W'($urandom_range(1, 4))
                                         : NUM_W'($urandom_range(0, 7));
      program_regs(num, rand_pair(1'b1), rand_pair(1'b1), rand_pair(1'b0),
                   rand_pair(1'b0), $urandom_range(0, 3) == 0);
      run_phase(count, $urandom_range(0, 99) < 70, 3);
      sent += count;
    end

    drain(SETTLE);
    if (sb.pending_slots.size() != 0) begin
      sb.mismatches++;
      $display("%0d results never arrived", sb.pending_slots.size());
    end
    if (sb.mismatches == 0)
      $display("** edf_tick_scheduler: PASSED **");
    else
      $display("** edf_tick_scheduler: FAILED **");
    $finish;
  end

endmodule
